// File: hdl/kmes_pkg.sv
// Shared types and constants for the keypad matrix event scanner.
// No dependencies; every other file but kmes_fifo imports this package.
package kmes_pkg;

  localparam int KEY_BITS        = 16;
  localparam int DEF_ROW_COUNT   = 4;
  localparam int DEF_COL_COUNT   = 4;
  localparam int QUEUE_DEPTH     = 2;
  localparam int IDLE_SCAN_FACTOR = 5;
  localparam logic [4:0] NO_KEY  = 5'd16;

  // Configuration register reset values
  localparam logic [15:0] RST_DEBOUNCE_MS   = 16'd50;
  localparam logic [15:0] RST_HOLD_MS       = 16'd800;
  localparam logic [15:0] RST_REPEAT_MS     = 16'd150;
  localparam logic [15:0] RST_SCAN_INTERVAL = 16'd1;
  localparam logic [31:0] RST_SLEEP_TIMEOUT = 32'd5000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DEBOUNCE      = 3'd0,
    REG_HOLD          = 3'd1,
    REG_REPEAT        = 3'd2,
    REG_SCAN_INTERVAL = 3'd3,
    REG_ACTIVE_LOW    = 3'd4,
    REG_INT_MODE      = 3'd5,
    REG_SLEEP_EN      = 3'd6,
    REG_SLEEP_TIMEOUT = 3'd7
  } cfg_reg_t;

  // Event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESSED = 2'd1,
    EV_HOLD    = 2'd2,
    EV_ERROR   = 2'd3
  } ev_t;

  // Error kinds
  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_ABSENT = 2'd1,
    ERR_BUS    = 2'd2
  } err_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] hold_ms;
    logic [15:0] repeat_ms;
    logic [15:0] scan_interval_ms;
    logic        level_active_low;
    logic        interrupt_mode;
    logic        sleep_enable;
    logic [31:0] sleep_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] column_levels;
    logic        bus_ok;
    logic        device_present;
    logic        change_seen;
  } poll_t;

  // Classified poll handed from the front end to the back end
  typedef struct packed {
    logic [31:0] now_ms;
    logic        any_down;
    logic        single_down;
    logic [3:0]  key_idx;
    logic        bus_ok;
    logic        device_present;
    logic        change_seen;
  } scan_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic [3:0] key_index;
    logic       key_valid;
    logic       in_power_save;
    logic [1:0] error_kind;
  } report_t;

endpackage

// File: hdl/kmes_fifo.sv
// Small first-in first-out queue of packed items.
// Depends on nothing; item type and depth come from the instantiating module.
module kmes_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  input  logic  pop,
  output item_t rd_item,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = store[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/kmes_front.sv
// Front end: applies polarity to the column sample and classifies it.
// Depends on kmes_pkg.
module kmes_front import kmes_pkg::*; #(
  parameter int ROW_COUNT = DEF_ROW_COUNT,
  parameter int COL_COUNT = DEF_COL_COUNT
) (
  input  poll_t poll,
  input  logic  level_active_low,
  output scan_t scan
);

  localparam int KEYS      = ROW_COUNT * COL_COUNT;
  localparam int VALID_POS = (KEYS < KEY_BITS) ? KEYS : KEY_BITS;

  logic [KEY_BITS-1:0] valid_mask;
  logic [KEY_BITS-1:0] pressed;
  logic [3:0]          last_idx;

  // Positions the matrix actually has
  always_comb begin
    for (int i = 0; i < KEY_BITS; i++) begin
      valid_mask[i] = (i < VALID_POS);
    end
  end

  assign pressed = (level_active_low ? ~poll.column_levels : poll.column_levels)
                   & valid_mask;

  // Highest pressed position
  always_comb begin
    last_idx = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      if (pressed[i]) begin
        last_idx = 4'(i);
      end
    end
  end

  always_comb begin
    scan.now_ms         = poll.now_ms;
    scan.any_down       = (pressed != '0);
    scan.single_down    = (pressed != '0) && ((pressed & (pressed - 1'b1)) == '0);
    scan.key_idx        = last_idx;
    scan.bus_ok         = poll.bus_ok;
    scan.device_present = poll.device_present;
    scan.change_seen    = poll.change_seen;
  end

endmodule

// File: hdl/kmes_back.sv
// Back end: debounce, hold-repeat, power save and event generation.
// Depends on kmes_pkg; consumes classified polls, produces one report each.
module kmes_back import kmes_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    sleep_clear,
  input  logic    take,
  input  scan_t   scan,
  output report_t report
);

  logic        key_down;
  logic [4:0]  current_key;
  logic [31:0] press_time;
  logic [31:0] repeat_time;
  logic [31:0] hold_start;
  logic [31:0] activity_time;
  logic [31:0] any_scan_time;
  logic [31:0] key_scan_time;
  logic        sleeping;
  logic        change_pending;

  logic        key_down_next;
  logic [4:0]  current_key_next;
  logic [31:0] press_time_next;
  logic [31:0] repeat_time_next;
  logic [31:0] hold_start_next;
  logic [31:0] activity_time_next;
  logic [31:0] any_scan_time_next;
  logic [31:0] key_scan_time_next;
  logic        sleeping_next;
  logic        change_pending_next;

  logic [15:0] base_iv;
  logic [18:0] idle_iv;
  logic [31:0] now;

  assign now     = scan.now_ms;
  assign base_iv = (cfg.scan_interval_ms == '0) ? 16'd1 : cfg.scan_interval_ms;
  assign idle_iv = {1'b0, base_iv, 2'b00} + {3'b000, base_iv};

  // Per-poll state update
  always_comb begin
    logic        ap_done;
    logic        ap_ret;
    logic        bus_err;
    logic        scan_err;
    logic [4:0]  scanned;
    logic [18:0] iv;
    logic [1:0]  ev;
    logic [1:0]  err;

    key_down_next       = key_down;
    current_key_next    = current_key;
    press_time_next     = press_time;
    repeat_time_next    = repeat_time;
    hold_start_next     = hold_start;
    activity_time_next  = activity_time;
    any_scan_time_next  = any_scan_time;
    key_scan_time_next  = key_scan_time;
    sleeping_next       = sleeping;
    change_pending_next = change_pending | scan.change_seen;
    ev       = EV_NONE;
    err      = ERR_OK;
    ap_done  = 1'b0;
    ap_ret   = 1'b0;
    bus_err  = 1'b0;
    scan_err = 1'b0;
    scanned  = NO_KEY;
    iv       = '0;

    if (!scan.device_present) begin
      ev  = EV_ERROR;
      err = ERR_ABSENT;
    end else begin
      // Wake on a signalled change
      if (sleeping_next && change_pending_next) begin
        sleeping_next      = 1'b0;
        activity_time_next = now;
      end
      if (!(cfg.interrupt_mode && !change_pending_next && !key_down && !sleeping_next)) begin
        // Presence check with power save handling
        if (cfg.sleep_enable) begin
          if (sleeping_next) begin
            ap_done = 1'b0;
            if (!change_pending_next) begin
              ap_done = 1'b1;
            end
          end else if (key_down) begin
            activity_time_next = now;
          end else if ((now - activity_time_next) > cfg.sleep_timeout_ms) begin
            sleeping_next = 1'b1;
            ap_done       = 1'b1;
          end
        end
        if (!ap_done) begin
          iv = sleeping_next ? idle_iv : {3'b000, base_iv};
          if (any_scan_time != '0 && (now - any_scan_time) < {13'd0, iv}) begin
            ap_ret = key_down;
          end else begin
            any_scan_time_next = now;
            if (!scan.bus_ok) begin
              bus_err = 1'b1;
              ap_ret  = key_down;
            end else if (scan.any_down) begin
              if (!sleeping_next) begin
                activity_time_next = now;
              end
              ap_ret = 1'b1;
            end
          end
        end

        if (!ap_ret) begin
          if (key_down) begin
            key_down_next      = 1'b0;
            current_key_next   = NO_KEY;
            hold_start_next    = '0;
            repeat_time_next   = '0;
            activity_time_next = now;
          end
          change_pending_next = 1'b0;
        end else begin
          // Key scan, rate limited
          if (sleeping_next) begin
            scanned = NO_KEY;
          end else if (key_scan_time != '0 && (now - key_scan_time) < {16'd0, base_iv}) begin
            scanned = current_key;
          end else begin
            key_scan_time_next = now;
            if (!scan.bus_ok) begin
              scan_err = 1'b1;
            end else begin
              if (scan.single_down) begin
                scanned            = {1'b0, scan.key_idx};
                activity_time_next = now;
              end
              bus_err = 1'b0;
            end
          end

          if (scan_err) begin
            ev  = EV_ERROR;
            err = ERR_BUS;
          end else if (scanned != NO_KEY) begin
            if (!key_down) begin
              if ((now - press_time) > {16'd0, cfg.debounce_ms}) begin
                key_down_next       = 1'b1;
                current_key_next    = scanned;
                hold_start_next     = now;
                repeat_time_next    = now;
                activity_time_next  = now;
                change_pending_next = 1'b0;
                ev                  = EV_PRESSED;
              end
            end else if (scanned == current_key) begin
              if ((now - hold_start) > {16'd0, cfg.hold_ms} &&
                  (now - repeat_time) > {16'd0, cfg.repeat_ms}) begin
                repeat_time_next    = now;
                activity_time_next  = now;
                change_pending_next = 1'b0;
                ev                  = EV_HOLD;
              end
            end else begin
              // A different key replaces the current one
              key_down_next       = 1'b0;
              current_key_next    = scanned;
              hold_start_next     = now;
              repeat_time_next    = now;
              press_time_next     = now;
              activity_time_next  = now;
              change_pending_next = 1'b0;
              ev                  = EV_PRESSED;
            end
          end else if (key_down && !bus_err) begin
            key_down_next       = 1'b0;
            current_key_next    = NO_KEY;
            hold_start_next     = '0;
            repeat_time_next    = '0;
            change_pending_next = 1'b0;
          end
        end
      end
    end

    report.event_code    = ev;
    report.key_index     = current_key_next[4] ? 4'd0 : current_key_next[3:0];
    report.key_valid     = !current_key_next[4];
    report.in_power_save = sleeping_next;
    report.error_kind    = err;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_down       <= 1'b0;
      current_key    <= NO_KEY;
      press_time     <= '0;
      repeat_time    <= '0;
      hold_start     <= '0;
      activity_time  <= '0;
      any_scan_time  <= '0;
      key_scan_time  <= '0;
      sleeping       <= 1'b0;
      change_pending <= 1'b0;
    end else if (sleep_clear) begin
      sleeping <= 1'b0;
    end else if (take) begin
      key_down       <= key_down_next;
      current_key    <= current_key_next;
      press_time     <= press_time_next;
      repeat_time    <= repeat_time_next;
      hold_start     <= hold_start_next;
      activity_time  <= activity_time_next;
      any_scan_time  <= any_scan_time_next;
      key_scan_time  <= key_scan_time_next;
      sleeping       <= sleeping_next;
      change_pending <= change_pending_next;
    end
  end

endmodule

// File: hdl/keypad_matrix_event_scanner.sv
// Keypad matrix event scanner, top level. Depends on kmes_pkg, kmes_front,
// kmes_back and kmes_fifo.
//
// Takes one poll per clock cycle while full is low and returns exactly one
// report per poll, in order. A pushed poll sits in the two-entry front queue,
// is worked by the back end's state update once the result queue has room, and
// its report is pushed into the result queue, where empty goes low and it waits
// to be popped. The rate is set by that state update, which closes on itself;
// the two-entry queues on each side let either side stall without losing a poll
// or a report. Configuration writes take effect at once and must be made only
// while no poll is in flight.
module keypad_matrix_event_scanner import kmes_pkg::*; #(
  parameter int ROW_COUNT = DEF_ROW_COUNT,
  parameter int COL_COUNT = DEF_COL_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  poll_t       poll,
  output logic        empty,
  input  logic        pop,
  output report_t     report,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  cfg_t    cfg;
  scan_t   scan_in;
  scan_t   scan_out;
  report_t back_report;
  logic    mid_empty;
  logic    out_full;
  logic    take;
  logic    sleep_clear;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms      <= RST_DEBOUNCE_MS;
      cfg.hold_ms          <= RST_HOLD_MS;
      cfg.repeat_ms        <= RST_REPEAT_MS;
      cfg.scan_interval_ms <= RST_SCAN_INTERVAL;
      cfg.level_active_low <= 1'b1;
      cfg.interrupt_mode   <= 1'b0;
      cfg.sleep_enable     <= 1'b0;
      cfg.sleep_timeout_ms <= RST_SLEEP_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_DEBOUNCE:      cfg.debounce_ms      <= cfg_wdata[15:0];
        REG_HOLD:          cfg.hold_ms          <= cfg_wdata[15:0];
        REG_REPEAT:        cfg.repeat_ms        <= cfg_wdata[15:0];
        REG_SCAN_INTERVAL: cfg.scan_interval_ms <= cfg_wdata[15:0];
        REG_ACTIVE_LOW:    cfg.level_active_low <= cfg_wdata[0];
        REG_INT_MODE:      cfg.interrupt_mode   <= cfg_wdata[0];
        REG_SLEEP_EN:      cfg.sleep_enable     <= cfg_wdata[0];
        REG_SLEEP_TIMEOUT: cfg.sleep_timeout_ms <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Disabling power save also wakes the block
  assign sleep_clear = cfg_we && (cfg_reg_t'(cfg_addr) == REG_SLEEP_EN) && !cfg_wdata[0];

  kmes_front #(
    .ROW_COUNT(ROW_COUNT),
    .COL_COUNT(COL_COUNT)
  ) u_front (
    .poll            (poll),
    .level_active_low(cfg.level_active_low),
    .scan            (scan_in)
  );

  kmes_fifo #(
    .item_t(scan_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_item(scan_in),
    .full   (full),
    .pop    (take),
    .rd_item(scan_out),
    .empty  (mid_empty)
  );

  // Back end works one poll whenever there is room for its report
  assign take = !mid_empty && !out_full;

  kmes_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .sleep_clear(sleep_clear),
    .take       (take),
    .scan       (scan_out),
    .report     (back_report)
  );

  kmes_fifo #(
    .item_t(report_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst    (rst),
    .push   (take),
    .wr_item(back_report),
    .full   (out_full),
    .pop    (pop),
    .rd_item(report),
    .empty  (empty)
  );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for keypad_matrix_event_scanner: directed and random polls,
// with the expected reports worked out by a behavioral copy of the scanner.
// Depends on kmes_pkg and the keypad_matrix_event_scanner RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kmes_pkg::*;

  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction before giving up
  localparam int SETTLE_TICKS = 4;     // quiet cycles after the last report
  localparam int HOLDOFF_LEN  = 80;    // long receiver stall in the pressure test

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  poll_t       poll = '0;
  logic        empty;
  logic        pop = 1'b0;
  report_t     report;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  keypad_matrix_event_scanner dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .poll(poll),
    .empty(empty), .pop(pop), .report(report),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Scanner settings as last written
  logic [15:0] c_debounce   = RST_DEBOUNCE_MS;
  logic [15:0] c_hold       = RST_HOLD_MS;
  logic [15:0] c_repeat     = RST_REPEAT_MS;
  logic [15:0] c_scan       = RST_SCAN_INTERVAL;
  bit          c_active_low = 1'b1;
  bit          c_int_mode   = 1'b0;
  bit          c_sleep_en   = 1'b0;
  logic [31:0] c_sleep_to   = RST_SLEEP_TIMEOUT;

  // Scanner state, tracked alongside the block
  bit          held        = 1'b0;
  logic [4:0]  cur_key     = NO_KEY;
  logic [31:0] press_t     = '0;
  logic [31:0] repeat_t    = '0;
  logic [31:0] hold_t      = '0;
  logic [31:0] active_t    = '0;
  logic [31:0] presence_t  = '0;  // zero means never scanned
  logic [31:0] keyscan_t   = '0;  // zero means never scanned
  bit          asleep      = 1'b0;
  bit          change_flag = 1'b0;

  report_t expected_reports[$];
  int      mismatches = 0;
  int      polls_sent = 0;
  int      burst_left = 0;
  int      pop_holdoff = 0;
  int      rx_cycle = 0;
  int      rx_mode = 0;
  int      quiet_cycles = 0;
  logic [31:0] ms_now = '0;

  function automatic logic [31:0] elapsed(input logic [31:0] now, input logic [31:0] since);
    return now - since;
  endfunction

  function automatic logic [31:0] eff_interval();
    return (c_scan == 16'd0) ? 32'd1 : {16'd0, c_scan};
  endfunction

  function automatic void wake_up(input logic [31:0] now);
    if (asleep) begin
      asleep = 1'b0;
      active_t = now;
    end
  endfunction

  function automatic void release_key();
    held = 1'b0;
    cur_key = NO_KEY;
    hold_t = '0;
    repeat_t = '0;
    change_flag = 1'b0;
  endfunction

  // Rate-limited "anything down" check; may enter or leave power save
  function automatic bit presence_check(input logic [31:0] now, input logic [15:0] pressed,
                                        input bit bus_ok, output bit bus_fault);
    logic [31:0] interval;
    bus_fault = 1'b0;
    if (c_sleep_en) begin
      if (asleep) begin
        if (!change_flag) return 1'b0;
        wake_up(now);
      end else if (held) begin
        active_t = now;
      end else if (elapsed(now, active_t) > c_sleep_to) begin
        asleep = 1'b1;
        return 1'b0;
      end
    end
    interval = eff_interval();
    if (asleep) interval = interval * IDLE_SCAN_FACTOR;
    if (presence_t != 0 && elapsed(now, presence_t) < interval) return held;
    presence_t = now;
    if (!bus_ok) begin
      bus_fault = 1'b1;
      return held;
    end
    if (pressed != 16'd0) begin
      if (!asleep) active_t = now;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the report for one accepted poll and queue it
  task automatic predict_report(input poll_t p);
    logic [31:0] now;
    logic [15:0] pressed;
    logic [4:0]  scanned;
    bit          bus_fault, scan_fault, done;
    ev_t         ev;
    err_t        fault;
    report_t     r;
    now = p.now_ms;
    pressed = c_active_low ? ~p.column_levels : p.column_levels;
    scanned = NO_KEY;
    bus_fault = 1'b0;
    scan_fault = 1'b0;
    done = 1'b0;
    ev = EV_NONE;
    fault = ERR_OK;
    if (p.change_seen) change_flag = 1'b1;

    // absent expander: report and leave the rest alone
    if (!p.device_present) begin
      ev = EV_ERROR;
      fault = ERR_ABSENT;
      done = 1'b1;
    end else begin
      if (asleep && change_flag) wake_up(now);
      if (c_int_mode && !change_flag && !held && !asleep) done = 1'b1;
    end

    if (!done) begin
      if (!presence_check(now, pressed, p.bus_ok, bus_fault)) begin
        if (held) begin
          release_key();
          active_t = now;
        end
        change_flag = 1'b0;
        done = 1'b1;
      end
    end

    // key scan, rate limited like the presence check
    if (!done) begin
      if (asleep) begin
        scanned = NO_KEY;
      end else if (keyscan_t != 0 && elapsed(now, keyscan_t) < eff_interval()) begin
        scanned = cur_key;
      end else begin
        keyscan_t = now;
        if (!p.bus_ok) begin
          scan_fault = 1'b1;
        end else begin
          if ($countones(pressed) == 1) begin
            for (int i = 0; i < KEY_BITS; i++)
              if (pressed[i]) scanned = 5'(i);
            active_t = now;
          end
          bus_fault = 1'b0;
        end
      end
      if (scan_fault) begin
        ev = EV_ERROR;
        fault = ERR_BUS;
        done = 1'b1;
      end
    end

    // debounce, hold repeat and release
    if (!done) begin
      if (scanned != NO_KEY) begin
        if (!held) begin
          if (elapsed(now, press_t) > c_debounce) begin
            held = 1'b1;
            cur_key = scanned;
            hold_t = now;
            repeat_t = now;
            active_t = now;
            change_flag = 1'b0;
            ev = EV_PRESSED;
          end
        end else if (scanned == cur_key) begin
          if (elapsed(now, hold_t) > c_hold && elapsed(now, repeat_t) > c_repeat) begin
            repeat_t = now;
            active_t = now;
            change_flag = 1'b0;
            ev = EV_HOLD;
          end
        end else begin
          // another key replaces the current one without a release
          held = 1'b0;
          cur_key = scanned;
          hold_t = now;
          repeat_t = now;
          press_t = now;
          active_t = now;
          change_flag = 1'b0;
          ev = EV_PRESSED;
        end
      end else if (held && !bus_fault) begin
        release_key();
      end
    end

    r.event_code    = ev;
    r.key_index     = (cur_key < NO_KEY) ? cur_key[3:0] : 4'd0;
    r.key_valid     = (cur_key < NO_KEY);
    r.in_power_save = asleep;
    r.error_kind    = fault;
    expected_reports.push_back(r);
  endtask

  function automatic poll_t poll_of(input logic [31:0] now, input logic [15:0] keys,
                                    input bit bus_ok, input bit present, input bit change);
    poll_t p;
    p.now_ms         = now;
    p.column_levels  = c_active_low ? ~keys : keys;
    p.bus_ok         = bus_ok;
    p.device_present = present;
    p.change_seen    = change;
    return p;
  endfunction

  // Send one poll; the sender runs in bursts with random gaps between them
  task automatic send_poll(input poll_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    push <= 1'b1;
    poll <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_report(p);
    polls_sent++;
  endtask

  // Stop sending and wait until every report has been taken
  task automatic wait_reports_done();
    @(negedge clk);
    push <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    wait_reports_done();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE:      c_debounce = value[15:0];
      REG_HOLD:          c_hold = value[15:0];
      REG_REPEAT:        c_repeat = value[15:0];
      REG_SCAN_INTERVAL: c_scan = value[15:0];
      REG_ACTIVE_LOW:    c_active_low = value[0];
      REG_INT_MODE:      c_int_mode = value[0];
      REG_SLEEP_EN: begin
        c_sleep_en = value[0];
        if (!value[0]) asleep = 1'b0;
      end
      REG_SLEEP_TIMEOUT: c_sleep_to = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] debounce, input logic [15:0] hold,
                                input logic [15:0] rep, input logic [15:0] scan,
                                input bit active_low, input bit int_mode,
                                input bit sleep_en, input logic [31:0] sleep_to);
    write_reg(REG_DEBOUNCE, 32'(debounce));
    write_reg(REG_HOLD, 32'(hold));
    write_reg(REG_REPEAT, 32'(rep));
    write_reg(REG_SCAN_INTERVAL, 32'(scan));
    write_reg(REG_ACTIVE_LOW, 32'(active_low));
    write_reg(REG_INT_MODE, 32'(int_mode));
    write_reg(REG_SLEEP_EN, 32'(sleep_en));
    write_reg(REG_SLEEP_TIMEOUT, sleep_to);
  endtask

  // A key (or key set) held for some polls, then released
  task automatic play_keystroke(input logic [15:0] keys, input int polls, input int step_hi);
    int rel;
    bit change;
    for (int i = 0; i < polls; i++) begin
      ms_now += $urandom_range(0, step_hi);
      change = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
      send_poll(poll_of(ms_now, keys, $urandom_range(0, 15) != 0,
                        $urandom_range(0, 23) != 0, change));
    end
    rel = $urandom_range(1, 4);
    for (int i = 0; i < rel; i++) begin
      ms_now += $urandom_range(1, step_hi + 1);
      send_poll(poll_of(ms_now, 16'h0, 1'b1, 1'b1, (i == 0) && ($urandom_range(0, 1) != 0)));
    end
  endtask

  task automatic play_idle(input int polls, input int step_hi);
    for (int i = 0; i < polls; i++) begin
      ms_now += $urandom_range(0, step_hi);
      send_poll(poll_of(ms_now, 16'h0, 1'b1, 1'b1, $urandom_range(0, 5) == 0));
    end
  endtask

  // Reset settings: zero timestamps, wrap, extreme levels, errors, key changes
  task automatic test_directed();
    send_poll(poll_of(32'd0, 16'h0000, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'd0, 16'h0001, 1'b1, 1'b1, 1'b1));
    send_poll(poll_of(32'd100, 16'h0001, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'd101, 16'h0001, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'd1000, 16'h0001, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'd1200, 16'h0001, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'd1201, 16'h0000, 1'b1, 1'b1, 1'b1));
    send_poll(poll_of(32'd1300, 16'h8000, 1'b1, 1'b1, 1'b1));
    send_poll(poll_of(32'd1301, 16'h8008, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'd1400, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    send_poll(poll_of(32'd1401, 16'h0000, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'd1500, 16'h0020, 1'b1, 1'b0, 1'b1));
    send_poll(poll_of(32'd1501, 16'h0020, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'd1502, 16'h0020, 1'b0, 1'b1, 1'b0));
    send_poll(poll_of(32'd1502, 16'h0020, 1'b0, 1'b1, 1'b0));
    send_poll(poll_of(32'd1503, 16'h0200, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'd1504, 16'h0200, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'd1600, 16'h0200, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'hFFFF_FFF0, 16'h0000, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'hFFFF_FFF8, 16'h0004, 1'b1, 1'b1, 1'b1));
    send_poll(poll_of(32'd5, 16'h0004, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'd6, 16'h0000, 1'b0, 1'b1, 1'b0));
    send_poll(poll_of(32'd7, 16'h0000, 1'b1, 1'b1, 1'b0));
    ms_now = 32'd7;
  endtask

  // Smallest timing settings with active-high polarity, then largest with active low
  task automatic test_timing_extremes();
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 32'd0);
    for (int i = 0; i < 6; i++)
      play_keystroke(16'h1 << $urandom_range(0, 15), $urandom_range(2, 6), 2);
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++)
      play_keystroke(16'h1 << $urandom_range(0, 15), $urandom_range(3, 6), 40000);
  endtask

  // Enter power save on inactivity, stay asleep without a change, wake on one
  task automatic test_power_save();
    apply_settings(16'd2, 16'd10, 16'd3, 16'd2, 1'b1, 1'b0, 1'b1, 32'd20);
    play_idle(8, 6);
    for (int i = 0; i < 4; i++) begin
      ms_now += $urandom_range(1, 12);
      send_poll(poll_of(ms_now, 16'h0010, 1'b1, 1'b1, 1'b0));
    end
    play_keystroke(16'h1 << $urandom_range(0, 15), 8, 4);
    play_idle(10, 6);
    // power save switched off while asleep
    write_reg(REG_SLEEP_EN, 32'd0);
    play_idle(4, 6);
    write_reg(REG_SLEEP_EN, 32'd1);
    write_reg(REG_SLEEP_TIMEOUT, 32'd0);
    play_idle(6, 2);
    play_keystroke(16'h1 << $urandom_range(0, 15), 6, 3);
    play_idle(4, 3);
  endtask

  // Interrupt mode: idle polls without a change are skipped
  task automatic test_interrupt_mode();
    apply_settings(16'd4, 16'd30, 16'd8, 16'd1, 1'b0, 1'b1, 1'b0, 32'd5000);
    play_idle(8, 3);
    for (int i = 0; i < 3; i++)
      play_keystroke(16'h1 << $urandom_range(0, 15), $urandom_range(6, 10), 5);
  endtask

  // Receiver stalls long enough for both queues to fill and push to stall
  task automatic test_backpressure();
    wait_reports_done();
    pop_holdoff = HOLDOFF_LEN;
    play_keystroke(16'h1 << $urandom_range(0, 15), 20, 3);
    wait_reports_done();
  endtask

  task automatic test_random_traffic();
    int step_hi, stop_at, pick;
    poll_t p;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          apply_settings(16'd3, 16'd20, 16'd5, 16'd1, 1'b1, 1'b0, 1'b1, 32'd60);
          step_hi = 4;
        end
        1: begin
          apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 32'd0);
          step_hi = 2;
        end
        2: begin
          apply_settings(16'd10, 16'd50, 16'd15, 16'd4, 1'b1, 1'b1, 1'b1, 32'd30);
          step_hi = 6;
        end
        default: begin
          apply_settings(RST_DEBOUNCE_MS, RST_HOLD_MS, RST_REPEAT_MS, RST_SCAN_INTERVAL,
                         1'b1, 1'b0, 1'b0, RST_SLEEP_TIMEOUT);
          step_hi = 60;
        end
      endcase
      stop_at = polls_sent + 55;
      while (polls_sent < stop_at) begin
        pick = $urandom_range(0, 15);
        if (pick <= 9) begin
          play_keystroke(16'h1 << $urandom_range(0, 15), $urandom_range(1, 20), step_hi);
        end else if (pick <= 11) begin
          play_keystroke(16'($urandom), $urandom_range(1, 6), step_hi);
        end else if (pick <= 13) begin
          play_idle($urandom_range(1, 8), step_hi * 4);
        end else if (pick == 14) begin
          // unstructured polls
          repeat (3) begin
            p.now_ms = $urandom;
            p.column_levels = 16'($urandom);
            p.bus_ok = 1'($urandom_range(0, 1));
            p.device_present = 1'($urandom_range(0, 1));
            p.change_seen = 1'($urandom_range(0, 1));
            send_poll(p);
          end
        end else begin
          ms_now = $urandom;
          play_keystroke(16'h1 << $urandom_range(0, 15), $urandom_range(1, 10), step_hi);
        end
      end
    end
  endtask

  // Receiver: stall pattern picked at random from four modes; long hold-off on request
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_holdoff > 0) begin
      pop <= 1'b0;
      pop_holdoff--;
    end else begin
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 1) != 0);
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= rx_cycle[3];
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each report transaction with the oldest expectation
  always @(posedge clk) begin
    report_t want;
    if (!rst && pop && !empty) begin
      if (expected_reports.size() == 0) begin
        $error("report with no poll outstanding: %p", report);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("event_code", 4'(want.event_code), 4'(report.event_code));
        check_field("key_index", want.key_index, report.key_index);
        check_field("key_valid", 4'(want.key_valid), 4'(report.key_valid));
        check_field("in_power_save", 4'(want.in_power_save), 4'(report.in_power_save));
        check_field("error_kind", 4'(want.error_kind), 4'(report.error_kind));
      end
    end
  end

  // Watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (rst || cfg_we || (push && !full) || (pop && !empty))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("keypad_matrix_event_scanner: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_timing_extremes();
    test_power_save();
    test_interrupt_mode();
    test_backpressure();
    test_random_traffic();
    wait_reports_done();
    repeat (10) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d reports never arrived", expected_reports.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("keypad_matrix_event_scanner: match");
    else
      $display("keypad_matrix_event_scanner: mismatch");
    $finish;
  end

endmodule
